// File: rtl/gslm_pkg.sv
// ----------------------------------------------------------------------------
// gslm_pkg: shared constants and helpers for the strict local maxima finder
// Defaults for sizes, register indexes, scan step codes and neighbor offsets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gslm_pkg;

    localparam int MAX_DIM_DEF    = 8;
    localparam int DATA_WIDTH_DEF = 16;
    localparam int MAX_RESULTS    = 16;
    localparam int QUEUE_DEPTH    = 4;

    // configuration port
    localparam int CFG_W   = 4;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

    // result field widths
    localparam int POS_W = 3;

    // scan step codes: read center, then eight neighbors, then compare, then decide
    localparam logic [3:0] STEP_CENTER   = 4'd0;
    localparam logic [3:0] STEP_LAST_RD  = 4'd8;
    localparam logic [3:0] STEP_LAST_CMP = 4'd9;
    localparam logic [3:0] STEP_DECIDE   = 4'd10;

    // row offset for a scan step
    function automatic logic signed [1:0] step_dr(input logic [3:0] step);
        logic signed [1:0] d;
        case (step)
            4'd1, 4'd2, 4'd3: d = -2'sd1;
            4'd6, 4'd7, 4'd8: d = 2'sd1;
            default:          d = 2'sd0;
        endcase
        return d;
    endfunction

    // column offset for a scan step
    function automatic logic signed [1:0] step_dc(input logic [3:0] step);
        logic signed [1:0] d;
        case (step)
            4'd1, 4'd4, 4'd6: d = -2'sd1;
            4'd3, 4'd5, 4'd8: d = 2'sd1;
            default:          d = 2'sd0;
        endcase
        return d;
    endfunction

endpackage

// File: rtl/grid_strict_local_maxima.sv
// ----------------------------------------------------------------------------
// grid_strict_local_maxima: strict 3x3 local maxima of a small signed matrix
// Loads a matrix in row-major order, then reports every cell greater than
// all eight neighbors, with cells outside the matrix taken as the minimum.
// ----------------------------------------------------------------------------
// Usage:
//   Write row_count (index 0) and col_count (index 1) while the block is idle;
//   both reset to 4, 0 counts as 1 and values above MAX_DIM count as MAX_DIM.
//   Send rows*cols values on i_valid/o_stall, one beat each, row-major.
//   Loading takes one value per cycle; o_stall stays low during loading.
//   After the final value o_stall rises for the scan, which takes each cell
//   through one store read per window position through the single read port,
//   one compare and one decide step, then closes out the matrix in a flush step.
//   Results leave on o_valid/i_stall through a 4-entry queue, one beat per
//   maximum in row-major order, o_last set on the final beat; a matrix with
//   no maximum yields one beat with o_found low and o_last high.
//   A stall on the output fills the queue and then holds the scan; input
//   resumes once the last result of the matrix is in the queue.
//   Reset (synchronous, active low) empties the queue, clears the load
//   count and the minimum, and restores the size registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_strict_local_maxima #(
    parameter int MAX_DIM    = gslm_pkg::MAX_DIM_DEF,
    parameter int DATA_WIDTH = gslm_pkg::DATA_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gslm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gslm_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [DATA_WIDTH-1:0]    i_value,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_found,
    output logic [gslm_pkg::POS_W-1:0]      o_row_index,
    output logic [gslm_pkg::POS_W-1:0]      o_col_index,
    output logic signed [DATA_WIDTH-1:0]    o_peak_value,
    output logic                            o_last
);
    import gslm_pkg::*;

    localparam int REC_W = 1 + 2 * POS_W + DATA_WIDTH + 1;

    logic             push;
    logic [REC_W-1:0] push_data;
    logic             full;
    logic [REC_W-1:0] q_data;

    gslm_front #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH),
        .REC_W      (REC_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_push      (push),
        .o_push_data (push_data),
        .i_full      (full)
    );

    gslm_queue #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (q_data)
    );

    // record layout: found, row, col, value, last
    assign o_found      = q_data[REC_W-1];
    assign o_row_index  = q_data[REC_W-2 -: POS_W];
    assign o_col_index  = q_data[REC_W-2-POS_W -: POS_W];
    assign o_peak_value = q_data[DATA_WIDTH:1];
    assign o_last       = q_data[0];

endmodule

// File: rtl/gslm_front.sv
// ----------------------------------------------------------------------------
// gslm_front: matrix loader and peak scanner
// Stores incoming values, tracks the minimum, then walks every cell reading
// its 3x3 window from the store and pushes result records to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gslm_front #(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 16,
    parameter int REC_W      = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gslm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gslm_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [DATA_WIDTH-1:0]    i_value,
    output logic                            o_push,
    output logic [REC_W-1:0]                o_push_data,
    input  logic                            i_full
);
    import gslm_pkg::*;

    localparam int CELLS = MAX_DIM * MAX_DIM;
    localparam int CW    = ($clog2(MAX_DIM + 1) > CFG_W) ? $clog2(MAX_DIM + 1) : CFG_W;
    localparam int TW    = 2 * CW;
    localparam int AW    = ($clog2(CELLS) > 1) ? $clog2(CELLS) : 1;
    localparam int LW    = ($clog2(CELLS + 1) > AW) ? $clog2(CELLS + 1) : AW;
    localparam int PW    = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {ST_LOAD, ST_SCAN, ST_FLUSH} t_state;

    t_state r_state, n_state;
    logic [CFG_W-1:0] r_rows_cfg, r_cols_cfg;
    logic [LW-1:0] r_cnt, n_cnt;
    logic signed [DATA_WIDTH-1:0] r_min, n_min;
    logic [CW-1:0] r_row, n_row, r_col, n_col;
    logic [3:0] r_step, n_step;
    logic signed [DATA_WIDTH-1:0] r_center, n_center;
    logic r_ok, n_ok;
    logic r_rd_inb, n_rd_inb;
    logic r_has_pend, n_has_pend;
    logic [CW-1:0] r_pend_row, n_pend_row, r_pend_col, n_pend_col;
    logic signed [DATA_WIDTH-1:0] r_pend_val, n_pend_val;
    logic [PW-1:0] r_npk, n_npk;

    logic signed [DATA_WIDTH-1:0] mem [CELLS];
    logic signed [DATA_WIDTH-1:0] r_rd_data;
    logic wr_en, rd_en;
    logic [AW-1:0] rd_addr;

    logic [CW-1:0] rows, cols;
    logic [TW-1:0] total;
    logic [LW-1:0] cnt_inc;
    logic signed [1:0] dr, dc;
    logic [CW:0] rr, cc;
    logic inb;
    logic [TW-1:0] nb_addr;
    logic signed [DATA_WIDTH-1:0] rd_val;
    logic last_cell;
    logic advance;
    logic [PW-1:0] npk_inc;

    function automatic logic [CW-1:0] clamp_dim(input logic [CFG_W-1:0] d);
        logic [CW-1:0] x;
        x = CW'(d);
        if (x == '0) begin
            return CW'(1);
        end else if (x > CW'(MAX_DIM)) begin
            return CW'(MAX_DIM);
        end
        return x;
    endfunction

    assign rows    = clamp_dim(r_rows_cfg);
    assign cols    = clamp_dim(r_cols_cfg);
    assign total   = TW'(rows) * TW'(cols);
    assign cnt_inc = r_cnt + 1'b1;

    // neighbor position for the current step; out of range reads as the minimum
    assign dr  = step_dr(r_step);
    assign dc  = step_dc(r_step);
    assign rr  = {1'b0, r_row} + {{(CW - 1){dr[1]}}, dr};
    assign cc  = {1'b0, r_col} + {{(CW - 1){dc[1]}}, dc};
    assign inb = !rr[CW] && !cc[CW] && (rr[CW-1:0] < rows) && (cc[CW-1:0] < cols);
    assign nb_addr = TW'(rr[CW-1:0]) * TW'(cols) + TW'(cc[CW-1:0]);
    assign rd_addr = nb_addr[AW-1:0];
    assign rd_val  = r_rd_inb ? r_rd_data : r_min;

    assign last_cell = (r_row == rows - 1'b1) && (r_col == cols - 1'b1);
    assign npk_inc   = r_npk + 1'b1;

    assign o_stall = (r_state != ST_LOAD);
    assign wr_en   = (r_state == ST_LOAD) && i_valid;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_min      = r_min;
        n_row      = r_row;
        n_col      = r_col;
        n_step     = r_step;
        n_center   = r_center;
        n_ok       = r_ok;
        n_rd_inb   = r_rd_inb;
        n_has_pend = r_has_pend;
        n_pend_row = r_pend_row;
        n_pend_col = r_pend_col;
        n_pend_val = r_pend_val;
        n_npk      = r_npk;
        rd_en       = 1'b0;
        o_push      = 1'b0;
        o_push_data = '0;
        advance     = 1'b0;
        case (r_state)
            ST_LOAD: begin
                if (i_valid) begin
                    if (r_cnt == '0 || i_value < r_min) begin
                        n_min = i_value;
                    end
                    if (TW'(cnt_inc) >= total) begin
                        n_cnt      = '0;
                        n_state    = ST_SCAN;
                        n_row      = '0;
                        n_col      = '0;
                        n_step     = STEP_CENTER;
                        n_has_pend = 1'b0;
                        n_npk      = '0;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
            end
            ST_SCAN: begin
                if (r_step <= STEP_LAST_RD) begin
                    rd_en    = inb;
                    n_rd_inb = inb;
                end
                if (r_step != STEP_CENTER && r_step <= STEP_LAST_CMP) begin
                    if (r_step == STEP_CENTER + 1'b1) begin
                        n_center = rd_val;
                        n_ok     = 1'b1;
                    end else if (!(r_center > rd_val)) begin
                        n_ok = 1'b0;
                    end
                end
                if (r_step != STEP_DECIDE) begin
                    n_step = r_step + 1'b1;
                end else begin
                    advance = 1'b1;
                    if (r_ok && r_has_pend) begin
                        // release the previous peak; it is not the last one
                        o_push      = 1'b1;
                        o_push_data = {1'b1, r_pend_row[POS_W-1:0], r_pend_col[POS_W-1:0],
                                       r_pend_val, 1'b0};
                        advance     = !i_full;
                    end
                    if (advance) begin
                        if (r_ok) begin
                            n_has_pend = 1'b1;
                            n_pend_row = r_row;
                            n_pend_col = r_col;
                            n_pend_val = r_center;
                            n_npk      = npk_inc;
                        end
                        if ((r_ok && npk_inc == PW'(MAX_RESULTS)) || last_cell) begin
                            n_state = ST_FLUSH;
                        end else begin
                            n_step = STEP_CENTER;
                            if (r_col == cols - 1'b1) begin
                                n_col = '0;
                                n_row = r_row + 1'b1;
                            end else begin
                                n_col = r_col + 1'b1;
                            end
                        end
                    end
                end
            end
            ST_FLUSH: begin
                o_push = 1'b1;
                if (r_has_pend) begin
                    o_push_data = {1'b1, r_pend_row[POS_W-1:0], r_pend_col[POS_W-1:0],
                                   r_pend_val, 1'b1};
                end else begin
                    o_push_data = {{(REC_W - 1){1'b0}}, 1'b1};
                end
                if (!i_full) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_rows_cfg <= CFG_W'(4);
            r_cols_cfg <= CFG_W'(4);
            r_cnt      <= '0;
            r_min      <= '0;
            r_has_pend <= 1'b0;
            r_npk      <= '0;
            r_step     <= STEP_CENTER;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_min      <= n_min;
            r_has_pend <= n_has_pend;
            r_npk      <= n_npk;
            r_step     <= n_step;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ROWS: r_rows_cfg <= i_cfg_data;
                    CFG_COLS: r_cols_cfg <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        r_row      <= n_row;
        r_col      <= n_col;
        r_center   <= n_center;
        r_ok       <= n_ok;
        r_rd_inb   <= n_rd_inb;
        r_pend_row <= n_pend_row;
        r_pend_col <= n_pend_col;
        r_pend_val <= n_pend_val;
    end

    // value store: one write port for loading, one registered read port for the scan
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_cnt[AW-1:0]] <= i_value;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/gslm_queue.sv
// ----------------------------------------------------------------------------
// gslm_queue: result queue
// Small register FIFO between the scanner and the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gslm_queue #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_W = ($clog2(DEPTH) > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = o_valid && !i_stall;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (do_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule
